// ----- rtl/queued_tone_sine_generator_assert.svh -----
// Assertion macros used by the checker file of the tone generator.
`ifndef QUEUED_TONE_SINE_GENERATOR_ASSERT_SVH
`define QUEUED_TONE_SINE_GENERATOR_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define QTSG_ASSERT_IMPLY(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error(msg);

// The condition holds in the cycle after the trigger.
`define QTSG_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/qtsg_pkg.sv -----
// Shared constants, types and the sine table builder of the tone generator.
package qtsg_pkg;

   localparam int QUEUE_DEPTH     = 16;
   localparam int SINE_TABLE_BITS = 10;
   localparam int PHASE_BITS      = 32;

   localparam int FREQ_W      = 25;
   localparam int MS_W        = 16;
   localparam int RATE_W      = 18;
   localparam int SAMPLE_W    = 16;
   localparam int SINE_MAG_W  = 15;
   localparam int LEVEL_OUT_W = 5;
   localparam int COUNT_W     = 24;
   localparam int FRAC_SHIFT  = PHASE_BITS - 8;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
   localparam int MS_PER_S = 1000;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // The duration product is divided by 1000 as a shift by 3 and then a
   // reciprocal multiply by ceil(2^38 / 125), exact for every 31-bit value.
   localparam int CNT_PROD_W = MS_W + RATE_W;
   localparam int MS_SHIFT   = 3;
   localparam int RCP_W      = 32;
   localparam int RCP_SHIFT  = 38;
   localparam logic [RCP_W-1:0] RCP_125 = RCP_W'(64'd2199023256);
   localparam int RCP_PROD_W = CNT_PROD_W - MS_SHIFT + RCP_W;
   localparam int RCP_Q_W    = RCP_PROD_W - RCP_SHIFT;

   // The divider only works on the scaled frequency.
   localparam int STEP_DIV_W = FREQ_W + FRAC_SHIFT;
   localparam int DIV_W      = STEP_DIV_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int QCOUNT_W = (LEVEL_W > LEVEL_OUT_W) ? LEVEL_W : LEVEL_OUT_W;
   localparam int ENTRY_W  = PHASE_BITS + COUNT_W;

   localparam int SINE_QUARTER = 1 << (SINE_TABLE_BITS - 2);
   localparam int SINE_IDX_W   = SINE_TABLE_BITS - 1;

   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [RATE_W-1:0] divisor;
   } qtsg_div_req_type;

   typedef struct packed {
      logic             busy;
      logic [DIV_W-1:0] quotient;
   } qtsg_div_stat_type;

   // Magnitude of one quarter-wave point, Q1.15, from the Taylor series in Q30.
   // Only used to build a constant table.
   function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned u);
      longint unsigned t;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned h;
      longint unsigned s;
      longint unsigned v;
      t  = longint'(u) << (30 - (SINE_TABLE_BITS - 2));
      x  = (t * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      h  = Q30_ONE - x2 / 72;
      h  = Q30_ONE - ((x2 * h) >> 30) / 42;
      h  = Q30_ONE - ((x2 * h) >> 30) / 20;
      h  = Q30_ONE - ((x2 * h) >> 30) / 6;
      s  = (x * h) >> 30;
      v  = (s * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) begin
         v = 32767;
      end
      return SINE_MAG_W'(v);
   endfunction

endpackage

// ----- rtl/qtsg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module qtsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/qtsg_divider.sv -----
// Restoring divider that retires one quotient bit per cycle.
module qtsg_divider
   import qtsg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  qtsg_div_req_type  req,
   output qtsg_div_stat_type stat
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [RATE_W-1:0]    den_ff, den_in;

   logic [RATE_W:0] trial;
   logic [RATE_W:0] diff;
   logic            fits;

   // The dividend shifts out of the top of the quotient register as quotient bits enter below.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.quotient = quo_ff;

endmodule

// ----- rtl/qtsg_sine.sv -----
// Quarter-wave sine table lookup with a registered Q1.15 sample.
module qtsg_sine
   import qtsg_pkg::*;
(
   input  logic                       clock,
   input  logic [PHASE_BITS-1:0]      phase,
   output logic signed [SAMPLE_W-1:0] sample
);

   localparam logic [SINE_IDX_W-1:0] QUARTER_IDX = SINE_IDX_W'(SINE_QUARTER);

   logic [SINE_MAG_W-1:0]      rom [SINE_QUARTER + 1];
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [1:0]                 quad;
   logic [SINE_IDX_W-1:0]      off;
   logic [SINE_IDX_W-1:0]      u;
   logic [SAMPLE_W-1:0]        mag;
   logic signed [SAMPLE_W-1:0] sample_ff;

   for (genvar g = 0; g <= SINE_QUARTER; g++) begin : g_rom
      assign rom[g] = sine_entry(unsigned'(g));
   end

   assign idx  = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign quad = idx[SINE_TABLE_BITS-1 -: 2];
   assign off  = {1'b0, idx[SINE_TABLE_BITS-3:0]};
   // Odd quadrants run the table backward, from the peak down.
   assign u    = quad[0] ? (QUARTER_IDX - off) : off;
   assign mag  = {1'b0, rom[u]};

   always_ff @(posedge clock) begin
      sample_ff <= quad[1] ? -signed'(mag) : signed'(mag);
   end

   assign sample = sample_ff;

endmodule

// ----- rtl/queued_tone_sine_generator.sv -----
// Tone generator: a queue of {phase step, sample count} pairs feeds a phase
// accumulator and a quarter-wave sine table. A tick item (tuser high) first
// waits while the queue memory and the sine table deliver their registered
// reads, and then the result is issued and the state is updated. An enqueue
// item runs through the multiply, reciprocal, check and enqueue states; a
// stored one also waits for the divider between check and enqueue. The
// sample count (duration times rate over 1000) comes from one multiply and a
// reciprocal multiply, each registered; the phase step (frequency times 2^24
// over rate) comes from the bit-serial divider, which produces one quotient
// bit a cycle and runs only for a stored tone. A result that is not taken
// stretches the item by the cycles it waits for the output register. The
// input is ready only between items; a finished result waits in an output
// register, and a new item may be accepted while it waits. The queue holds
// 16 tones and the sample rate register resets to 48000 Hz.
module queued_tone_sine_generator
   import qtsg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [24:0] tone_freq, [40:25] duration_ms, [47:41] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] func
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] sample, [16] tone_active, [17] enqueue_accepted, [22:18] queue_level, [23] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [RATE_W-1:0]      csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_RCP  = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_DIVS = 3'd4;
   localparam logic [2:0] ST_ENQ  = 3'd5;
   localparam logic [2:0] ST_TICK = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic [FREQ_W-1:0]        freq_ff, freq_in;
   logic [MS_W-1:0]          ms_ff, ms_in;
   logic [CNT_PROD_W-1:0]    prod_ff, prod_in;
   logic [COUNT_W-1:0]       n_ff, n_in;
   logic                     ok_ff, ok_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   logic [QCOUNT_W-1:0]      count_ff, count_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;

   qtsg_div_req_type         div_req;
   qtsg_div_stat_type        div_stat;

   logic                     ram_we;
   logic [PTR_W-1:0]         ram_waddr;
   logic [ENTRY_W-1:0]       ram_wdata;
   logic [ENTRY_W-1:0]       ram_rdata;

   logic signed [SAMPLE_W-1:0] sine_sample;

   logic                     req_accept;
   logic                     rsp_free;
   logic [CNT_PROD_W-1:0]    dur_prod;
   logic [RCP_PROD_W-1:0]    rcp_prod;
   logic [RCP_Q_W-1:0]       rcp_quo;
   logic [COUNT_W-1:0]       n_sat;
   logic [PHASE_BITS-1:0]    head_step;
   logic [COUNT_W-1:0]       head_left;
   logic [COUNT_W-1:0]       left_dec;
   logic [PTR_W-1:0]         head_next;
   logic [PTR_W-1:0]         tail_next;

   qtsg_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   qtsg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_tone_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   qtsg_sine u_sine (
      .clock  (clock),
      .phase  (phase_ff),
      .sample (sine_sample)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign dur_prod  = CNT_PROD_W'(ms_ff) * CNT_PROD_W'(rate_ff);
   // Division by 1000: drop three bits, then multiply by the reciprocal of 125.
   assign rcp_prod  = RCP_PROD_W'(prod_ff[CNT_PROD_W-1:MS_SHIFT]) * RCP_PROD_W'(RCP_125);
   assign rcp_quo   = rcp_prod[RCP_PROD_W-1:RCP_SHIFT];
   assign n_sat     = (|rcp_quo[RCP_Q_W-1:COUNT_W]) ? '1 : rcp_quo[COUNT_W-1:0];
   assign head_step = ram_rdata[ENTRY_W-1 -: PHASE_BITS];
   assign head_left = ram_rdata[COUNT_W-1:0];
   assign left_dec  = head_left - 1'b1;
   assign head_next = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      rate_in      = csr_we ? csr_wdata : rate_ff;
      freq_in      = freq_ff;
      ms_in        = ms_ff;
      prod_in      = prod_ff;
      n_in         = n_ff;
      ok_in        = ok_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;
      ram_we       = 1'b0;
      ram_waddr    = tail_ff;
      ram_wdata    = {div_stat.quotient[PHASE_BITS-1:0], n_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               freq_in  = req_tdata[FREQ_W-1:0];
               ms_in    = req_tdata[FREQ_W +: MS_W];
               state_in = (req_tuser[0] == FUNC_TICK) ? ST_TICK : ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = dur_prod;
            state_in = ST_RCP;
         end
         ST_RCP: begin
            n_in     = n_sat;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // Zero-length tones and a full queue drop the item without a division.
            if ((n_ff != '0) && (count_ff < QCOUNT_W'(QUEUE_DEPTH))) begin
               ok_in            = 1'b1;
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'({freq_ff, {FRAC_SHIFT{1'b0}}});
               div_req.divisor  = rate_ff;
               state_in         = ST_DIVS;
            end else begin
               ok_in    = 1'b0;
               state_in = ST_ENQ;
            end
         end
         ST_DIVS: begin
            if (!div_stat.busy) begin
               state_in = ST_ENQ;
            end
         end
         ST_ENQ: begin
            if (rsp_free) begin
               if (ok_ff) begin
                  ram_we   = 1'b1;
                  tail_in  = tail_next;
                  count_in = count_ff + 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({count_in[LEVEL_OUT_W-1:0], ok_ff, 1'b0,
                                            {SAMPLE_W{1'b0}}});
               state_in     = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (rsp_free) begin
               if (count_ff != '0) begin
                  phase_in = phase_ff + head_step;
                  if (left_dec == '0) begin
                     head_in  = head_next;
                     count_in = count_ff - 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = head_ff;
                     ram_wdata = {head_step, left_dec};
                  end
                  rsp_data_in = RSP_TDATA_W'({count_in[LEVEL_OUT_W-1:0], 1'b0, 1'b1,
                                              sine_sample});
               end else begin
                  rsp_data_in = RSP_TDATA_W'({count_ff[LEVEL_OUT_W-1:0], 1'b0, 1'b0,
                                              {SAMPLE_W{1'b0}}});
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_RESET;
         ok_ff        <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         ok_ff        <= ok_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      freq_ff     <= freq_in;
      ms_ff       <= ms_in;
      prod_ff     <= prod_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/qtsg_checker.sv -----
// Port-level assertions for the tone generator and their binding.
`include "queued_tone_sine_generator_assert.svh"

module qtsg_checker
   import qtsg_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result keeps its value until it is taken.
   `QTSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // The block works on one item at a time, so it is busy right after taking one.
   `QTSG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "input ready right after an accepted item")

   // A stored tone carries no sample and leaves at least one tone queued.
   `QTSG_ASSERT_IMPLY(a_enq_result, clock, reset, rsp_tvalid && rsp_tdata[17], (rsp_tdata[15:0] == 16'd0) && !rsp_tdata[16] && (rsp_tdata[22:18] != 5'd0), "bad result for a stored tone")

   // Only a playing tone produces a nonzero sample.
   `QTSG_ASSERT_IMPLY(a_silence_idle, clock, reset, rsp_tvalid && (rsp_tdata[15:0] != 16'd0), rsp_tdata[16], "nonzero sample without a tone")

endmodule

bind queued_tone_sine_generator qtsg_checker u_qtsg_checker (.*);

// ----- dv/queued_tone_sine_generator_test.sv -----
// Self-checking testbench of the queued tone sine generator: directed and random traffic.
module queued_tone_sine_generator_test;
   import qtsg_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int TIMEOUT_CYCLES = 2000000;
   localparam int DRAIN_CYCLES   = 20000;
   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       active;
      logic                       accepted;
      logic [LEVEL_OUT_W-1:0]     level;
   } tone_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]             req_tuser  = FUNC_ENQUEUE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [RATE_W-1:0]      csr_wdata  = '0;

   // Own copy of the generator state.
   logic [RATE_W-1:0]     gen_rate = RATE_RESET;
   logic [PHASE_BITS-1:0] gen_step [QUEUE_DEPTH];
   logic [COUNT_W-1:0]    gen_left [QUEUE_DEPTH];
   int                    gen_head  = 0;
   int                    gen_tail  = 0;
   int                    gen_count = 0;
   logic [PHASE_BITS-1:0] gen_phase = '0;

   tone_result_type tone_expected[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches    = 0;
   int items_sent    = 0;
   int ticks_active  = 0;
   int ticks_silent  = 0;
   int tones_stored  = 0;
   int drops_empty   = 0;
   int drops_full    = 0;

   queued_tone_sine_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Quarter-wave sine of the top table bits of a phase, in Q1.15.
   function automatic logic signed [SAMPLE_W-1:0] sine_of_phase(input logic [PHASE_BITS-1:0] ph);
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [1:0]                 quad;
      longint unsigned            off;
      longint unsigned            u;
      longint unsigned            x;
      longint unsigned            x2;
      longint unsigned            h;
      longint unsigned            s;
      longint unsigned            mag;
      idx  = ph >> (PHASE_BITS - SINE_TABLE_BITS);
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      off  = idx & (SINE_QUARTER - 1);
      u    = quad[0] ? (SINE_QUARTER - off) : off;
      x    = ((u << (30 - (SINE_TABLE_BITS - 2))) * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      h    = Q30_ONE - x2 / 72;
      h    = Q30_ONE - ((x2 * h) >> 30) / 42;
      h    = Q30_ONE - ((x2 * h) >> 30) / 20;
      h    = Q30_ONE - ((x2 * h) >> 30) / 6;
      s    = (x * h) >> 30;
      mag  = (s * 32767 + (64'd1 << 29)) >> 30;
      if (mag > 32767) begin
         mag = 32767;
      end
      return quad[1] ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
   endfunction

   // Applies one item to the generator state and returns the result it causes.
   function automatic tone_result_type advance_tone_model(input logic func,
                                                           input logic [FREQ_W-1:0] freq,
                                                           input logic [MS_W-1:0] ms);
      tone_result_type res;
      longint unsigned n;
      longint unsigned wide_freq;
      res = '0;
      if (func == FUNC_ENQUEUE) begin
         n = (longint'(ms) * gen_rate) / MS_PER_S;
         if (n > COUNT_MAX) begin
            n = COUNT_MAX;
         end
         if (n == 0) begin
            drops_empty++;
         end else if (gen_count == QUEUE_DEPTH) begin
            drops_full++;
         end else begin
            wide_freq = freq;
            gen_step[gen_tail] = PHASE_BITS'((wide_freq << FRAC_SHIFT) / gen_rate);
            gen_left[gen_tail] = COUNT_W'(n);
            gen_tail = (gen_tail + 1) % QUEUE_DEPTH;
            gen_count++;
            res.accepted = 1'b1;
            tones_stored++;
         end
      end else if (gen_count != 0) begin
         res.sample = sine_of_phase(gen_phase);
         res.active = 1'b1;
         gen_phase  = gen_phase + gen_step[gen_head];
         if (gen_left[gen_head] != 0) begin
            gen_left[gen_head] = gen_left[gen_head] - 1'b1;
         end
         if (gen_left[gen_head] == 0) begin
            gen_head = (gen_head + 1) % QUEUE_DEPTH;
            gen_count--;
         end
         ticks_active++;
      end else begin
         ticks_silent++;
      end
      res.level = LEVEL_OUT_W'(gen_count);
      return res;
   endfunction

   // Offers one item and records its expected result once it is taken.
   task automatic send_item(input logic func, input logic [FREQ_W-1:0] freq,
                            input logic [MS_W-1:0] ms);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {{(REQ_TDATA_W - FREQ_W - MS_W){1'b0}}, ms, freq};
      do @(posedge clock); while (!req_tready);
      tone_expected.push_back(advance_tone_model(func, freq, ms));
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(FUNC_TICK, FREQ_W'($urandom), MS_W'($urandom));
   endtask

   // Holds the sender back until every pending result has been taken.
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (tone_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_rate(input logic [RATE_W-1:0] rate);
      wait_results_done();
      csr_we    <= 1'b1;
      csr_wdata <= rate;
      @(posedge clock);
      csr_we    <= 1'b0;
      gen_rate = rate;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
   endtask

   // Enqueues mostly short tones so the queue both fills up and drains.
   task automatic send_random_item(input int enq_pct);
      logic [MS_W-1:0] ms;
      int              short_ms;
      if ($urandom_range(99) < enq_pct) begin
         short_ms = (gen_rate == 0) ? 1 : 16000 / gen_rate;
         if (short_ms < 1) begin
            short_ms = 1;
         end
         // A dropped enqueue may carry any duration without leaving a long tone behind.
         if (gen_rate == 0 || gen_count == QUEUE_DEPTH) begin
            ms = MS_W'($urandom);
         end else if ($urandom_range(99) < 6) begin
            ms = '0;
         end else begin
            ms = MS_W'($urandom_range(short_ms, 1));
         end
         send_item(FUNC_ENQUEUE, FREQ_W'($urandom), ms);
      end else begin
         send_tick();
      end
   endtask

   task automatic test_silence_and_empty_tone();
      send_tick();
      send_item(FUNC_ENQUEUE, FREQ_W'(3072000), '0);
      send_tick();
   endtask

   // A 12 kHz tone at the reset rate steps a quarter wave per sample.
   task automatic test_reset_rate_quadrants();
      send_item(FUNC_ENQUEUE, FREQ_W'(3072000), MS_W'(1));
      repeat (5) send_tick();
   endtask

   task automatic test_zero_rate();
      set_rate('0);
      send_item(FUNC_ENQUEUE, '1, '1);
      send_item(FUNC_ENQUEUE, '0, MS_W'(1));
      send_tick();
   endtask

   task automatic test_extreme_fields();
      set_rate(RATE_W'(1000));
      send_item(FUNC_ENQUEUE, '1, MS_W'(1));
      send_item(FUNC_ENQUEUE, '0, MS_W'(2));
      send_item(FUNC_ENQUEUE, FREQ_W'(1), MS_W'(3));
      repeat (2) send_tick();
   endtask

   task automatic test_random_traffic();
      int rates [8]    = '{1000, 8000, 44100, 192000, 1, 1000, 8000, 48000};
      int send_pct [4] = '{0, 57, 0, 30};
      int rsp_pct [4]  = '{0, 0, 57, 30};
      for (int seg = 0; seg < 8; seg++) begin
         set_rate(RATE_W'(rates[seg]));
         set_idling(send_pct[seg / 2], rsp_pct[seg / 2]);
         repeat (238) send_random_item((seg % 2 == 1) ? 8 : 15);
      end
      set_idling(0, 0);
   endtask

   // The count saturates at the highest rate; this tone outlasts the run.
   task automatic test_saturated_count();
      set_rate('1);
      send_item(FUNC_ENQUEUE, '1, '1);
      send_item(FUNC_ENQUEUE, FREQ_W'(256), MS_W'(1));
      repeat (3) send_tick();
   endtask

   always @(posedge clock) begin : rsp_monitor
      tone_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tone_expected.size() == 0) begin
            $error("Result with no item pending: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = tone_expected.pop_front();
            if (rsp_tdata[15:0] !== want.sample) begin
               $error("sample: expected %0d, actual %0d", want.sample,
                      $signed(rsp_tdata[15:0]));
               mismatches++;
            end
            if (rsp_tdata[16] !== want.active) begin
               $error("tone_active: expected %0d, actual %0d", want.active, rsp_tdata[16]);
               mismatches++;
            end
            if (rsp_tdata[17] !== want.accepted) begin
               $error("enqueue_accepted: expected %0d, actual %0d", want.accepted,
                      rsp_tdata[17]);
               mismatches++;
            end
            if (rsp_tdata[22:18] !== want.level) begin
               $error("queue_level: expected %0d, actual %0d", want.level, rsp_tdata[22:18]);
               mismatches++;
            end
         end
      end
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      int waited;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_silence_and_empty_tone();
      test_reset_rate_quadrants();
      test_zero_rate();
      test_extreme_fields();
      test_random_traffic();
      test_saturated_count();
      req_tvalid <= 1'b0;
      waited = 0;
      while (tone_expected.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (tone_expected.size() != 0) begin
         $error("%0d results never arrived", tone_expected.size());
         mismatches++;
      end
      $display("Sent %0d items: %0d ticks from queued tones, %0d silent ticks.",
               items_sent, ticks_active, ticks_silent);
      $display("Tones stored %0d, dropped as empty %0d, dropped on a full queue %0d.",
               tones_stored, drops_empty, drops_full);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/qtsg_pkg.sv
rtl/qtsg_ram.sv
rtl/qtsg_divider.sv
rtl/qtsg_sine.sv
rtl/queued_tone_sine_generator.sv
rtl/qtsg_checker.sv
dv/queued_tone_sine_generator_test.sv
